>>> rtl/prfi_pkg.sv
`timescale 1ns / 1ps

package prfi_pkg;

    // Item kinds carried on the func field.
    typedef enum logic [2:0] {
        FUNC_READ       = 3'd0,
        FUNC_WRITE      = 3'd1,
        FUNC_IRQ_RAISE  = 3'd2,
        FUNC_DMA_DONE   = 3'd3,
        FUNC_DMA_ERROR  = 3'd4,
        FUNC_CONSUME_RX = 3'd5
    } t_func;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 5;
    localparam int IRQ_W   = 3;

    // Register map.
    localparam logic [INDEX_W-1:0] REG_UART_TXDATA  = 5'd0;
    localparam logic [INDEX_W-1:0] REG_UART_RXDATA  = 5'd1;
    localparam logic [INDEX_W-1:0] REG_UART_STATUS  = 5'd2;
    localparam logic [INDEX_W-1:0] REG_UART_CTRL    = 5'd3;
    localparam logic [INDEX_W-1:0] REG_UART_BAUDDIV = 5'd4;
    localparam logic [INDEX_W-1:0] REG_TIMER_CTRL   = 5'd5;
    localparam logic [INDEX_W-1:0] REG_TIMER_LOAD   = 5'd6;
    localparam logic [INDEX_W-1:0] REG_DMA_SRC      = 5'd10;
    localparam logic [INDEX_W-1:0] REG_DMA_DST      = 5'd11;
    localparam logic [INDEX_W-1:0] REG_DMA_LEN      = 5'd12;
    localparam logic [INDEX_W-1:0] REG_DMA_CTRL     = 5'd13;
    localparam logic [INDEX_W-1:0] REG_DMA_STATUS   = 5'd14;
    localparam logic [INDEX_W-1:0] REG_DMA_ERR_CODE = 5'd15;
    localparam logic [INDEX_W-1:0] REG_DMA_IRQ_CLR  = 5'd16;
    localparam logic [INDEX_W-1:0] REG_INTC_ENABLE  = 5'd17;
    localparam logic [INDEX_W-1:0] REG_INTC_PENDING = 5'd18;
    localparam logic [INDEX_W-1:0] REG_INTC_ACK     = 5'd19;
    localparam logic [INDEX_W-1:0] REG_INTC_ACTIVE  = 5'd20;
    localparam logic [INDEX_W-1:0] REG_INTC_CLEAR   = 5'd21;
    localparam logic [INDEX_W-1:0] REG_PERF_FIRST   = 5'd22;
    localparam logic [INDEX_W-1:0] REG_PERF_LAST    = 5'd26;
    localparam logic [INDEX_W-1:0] REG_PERF_CTRL    = 5'd27;

    localparam int PERF_COUNT = 5;
    localparam int PERF_SEL_W = $clog2(PERF_COUNT);

    // Interrupt line numbers.
    localparam logic [1:0] IRQ_UART  = 2'd0;
    localparam logic [1:0] IRQ_TIMER = 2'd1;
    localparam logic [1:0] IRQ_DMA   = 2'd2;

    localparam logic [DATA_W-1:0] ACK_NONE       = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] UART_TX_EMPTY  = 32'h0000_0002;
    localparam logic [2:0]        DMA_ST_BUSY    = 3'b001;
    localparam logic [2:0]        DMA_ST_DONE    = 3'b010;
    localparam logic [2:0]        DMA_ST_ERROR   = 3'b100;
    localparam int                DMA_CTRL_START = 0;
    localparam int                DMA_CTRL_IRQEN = 1;
    localparam int                PERF_CTRL_CLR  = 1;

    typedef struct packed {
        t_func               func;
        logic [INDEX_W-1:0]  reg_index;
        logic [DATA_W-1:0]   write_data;
    } t_req;

endpackage

>>> rtl/prfi_regs.sv
`timescale 1ns / 1ps

module prfi_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  prfi_pkg::t_req        i_req,
    output logic [prfi_pkg::DATA_W-1:0] o_read_data
);
    import prfi_pkg::*;

    logic [DATA_W-1:0]     r_uart_ctrl, n_uart_ctrl;
    logic [DATA_W-1:0]     r_uart_baud, n_uart_baud;
    logic [7:0]            r_rx_byte, n_rx_byte;
    logic                  r_rx_valid, n_rx_valid;
    logic [DATA_W-1:0]     r_timer_ctrl, n_timer_ctrl;
    logic [DATA_W-1:0]     r_timer_load, n_timer_load;
    logic [DATA_W-1:0]     r_dma_src, n_dma_src;
    logic [DATA_W-1:0]     r_dma_dst, n_dma_dst;
    logic [DATA_W-1:0]     r_dma_len, n_dma_len;
    logic [DATA_W-1:0]     r_dma_ctrl, n_dma_ctrl;
    logic [2:0]            r_dma_status, n_dma_status;
    logic [DATA_W-1:0]     r_dma_err, n_dma_err;
    logic [IRQ_W-1:0]      r_irq_en, n_irq_en;
    logic [IRQ_W-1:0]      r_irq_pend, n_irq_pend;
    logic [IRQ_W-1:0]      r_irq_act, n_irq_act;
    logic [DATA_W-1:0]     r_perf [PERF_COUNT];
    logic [DATA_W-1:0]     n_perf [PERF_COUNT];
    logic [DATA_W-1:0]     r_perf_ctrl, n_perf_ctrl;

    logic [IRQ_W-1:0]      irq_ready;
    logic [1:0]            ack_line;
    logic [IRQ_W-1:0]      ack_mask;
    logic [PERF_SEL_W-1:0] perf_sel;
    logic [IRQ_W-1:0]      raise_mask;
    logic [IRQ_W-1:0]      clear_mask;
    logic [4:0]            clear_bit;

    // Fixed-priority pick: TIMER first, then DMA, then UART.
    assign irq_ready = r_irq_pend & r_irq_en;
    always_comb begin
        if (irq_ready[IRQ_TIMER]) begin
            ack_line = IRQ_TIMER;
        end else if (irq_ready[IRQ_DMA]) begin
            ack_line = IRQ_DMA;
        end else begin
            ack_line = IRQ_UART;
        end
    end

    always_comb begin
        ack_mask   = '0;
        raise_mask = '0;
        clear_mask = '0;
        ack_mask[ack_line] = 1'b1;
        if (i_req.write_data[1:0] != 2'd3) begin
            raise_mask[i_req.write_data[1:0]] = 1'b1;
        end
        clear_bit = i_req.write_data[4:0];
        if (clear_bit < 5'd3) begin
            clear_mask[clear_bit[1:0]] = 1'b1;
        end
    end

    assign perf_sel = PERF_SEL_W'(i_req.reg_index - REG_PERF_FIRST);

    always_comb begin
        n_uart_ctrl  = r_uart_ctrl;
        n_uart_baud  = r_uart_baud;
        n_rx_byte    = r_rx_byte;
        n_rx_valid   = r_rx_valid;
        n_timer_ctrl = r_timer_ctrl;
        n_timer_load = r_timer_load;
        n_dma_src    = r_dma_src;
        n_dma_dst    = r_dma_dst;
        n_dma_len    = r_dma_len;
        n_dma_ctrl   = r_dma_ctrl;
        n_dma_status = r_dma_status;
        n_dma_err    = r_dma_err;
        n_irq_en     = r_irq_en;
        n_irq_pend   = r_irq_pend;
        n_irq_act    = r_irq_act;
        n_perf       = r_perf;
        n_perf_ctrl  = r_perf_ctrl;
        o_read_data  = '0;

        case (i_req.func)
            FUNC_READ: begin
                case (i_req.reg_index) inside
                    REG_UART_RXDATA:  o_read_data = DATA_W'(r_rx_byte);
                    REG_UART_STATUS:  o_read_data = UART_TX_EMPTY
                                                  | DATA_W'({r_rx_valid, 2'b00});
                    REG_UART_CTRL:    o_read_data = r_uart_ctrl;
                    REG_UART_BAUDDIV: o_read_data = r_uart_baud;
                    REG_TIMER_CTRL:   o_read_data = r_timer_ctrl;
                    REG_TIMER_LOAD:   o_read_data = r_timer_load;
                    REG_DMA_SRC:      o_read_data = r_dma_src;
                    REG_DMA_DST:      o_read_data = r_dma_dst;
                    REG_DMA_LEN:      o_read_data = r_dma_len;
                    REG_DMA_CTRL:     o_read_data = r_dma_ctrl;
                    REG_DMA_STATUS:   o_read_data = DATA_W'(r_dma_status);
                    REG_DMA_ERR_CODE: o_read_data = r_dma_err;
                    REG_INTC_ENABLE:  o_read_data = DATA_W'(r_irq_en);
                    REG_INTC_PENDING: o_read_data = DATA_W'(r_irq_pend);
                    REG_INTC_ACK: begin
                        if (irq_ready != '0) begin
                            o_read_data = DATA_W'(ack_line);
                            n_irq_pend  = r_irq_pend & ~ack_mask;
                            n_irq_act   = r_irq_act | ack_mask;
                        end else begin
                            o_read_data = ACK_NONE;
                        end
                    end
                    REG_INTC_ACTIVE:  o_read_data = DATA_W'(r_irq_act);
                    [REG_PERF_FIRST:REG_PERF_LAST]: o_read_data = r_perf[perf_sel];
                    REG_PERF_CTRL:    o_read_data = r_perf_ctrl;
                    default:          o_read_data = '0;
                endcase
            end
            FUNC_WRITE: begin
                case (i_req.reg_index) inside
                    REG_UART_TXDATA: begin
                        n_rx_byte  = i_req.write_data[7:0];
                        n_rx_valid = 1'b1;
                    end
                    REG_UART_CTRL:    n_uart_ctrl  = i_req.write_data;
                    REG_UART_BAUDDIV: n_uart_baud  = i_req.write_data;
                    REG_TIMER_CTRL:   n_timer_ctrl = i_req.write_data;
                    REG_TIMER_LOAD:   n_timer_load = i_req.write_data;
                    REG_DMA_SRC:      n_dma_src    = i_req.write_data;
                    REG_DMA_DST:      n_dma_dst    = i_req.write_data;
                    REG_DMA_LEN:      n_dma_len    = i_req.write_data;
                    REG_DMA_CTRL: begin
                        if (i_req.write_data[DMA_CTRL_START]) begin
                            n_dma_status = DMA_ST_BUSY;
                            n_dma_err    = '0;
                        end
                        n_dma_ctrl = i_req.write_data;
                        n_dma_ctrl[DMA_CTRL_START] = 1'b0;
                    end
                    REG_DMA_IRQ_CLR: begin
                        n_dma_status = '0;
                        n_dma_err    = '0;
                    end
                    REG_INTC_ENABLE:  n_irq_en  = i_req.write_data[IRQ_W-1:0];
                    REG_INTC_CLEAR:   n_irq_act = r_irq_act & ~clear_mask;
                    [REG_PERF_FIRST:REG_PERF_LAST]: n_perf[perf_sel] = i_req.write_data;
                    REG_PERF_CTRL: begin
                        n_perf_ctrl = i_req.write_data;
                        if (i_req.write_data[PERF_CTRL_CLR]) begin
                            for (int k = 0; k < PERF_COUNT; k++) begin
                                n_perf[k] = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_IRQ_RAISE: begin
                // Line numbers of three or more are ignored.
                if (i_req.write_data[DATA_W-1:2] == '0) begin
                    n_irq_pend = r_irq_pend | raise_mask;
                end
            end
            FUNC_DMA_DONE: begin
                n_dma_status = DMA_ST_DONE;
                if (r_dma_ctrl[DMA_CTRL_IRQEN]) begin
                    n_irq_pend[IRQ_DMA] = 1'b1;
                end
            end
            FUNC_DMA_ERROR: begin
                n_dma_status = DMA_ST_ERROR;
                n_dma_err    = i_req.write_data;
                if (r_dma_ctrl[DMA_CTRL_IRQEN]) begin
                    n_irq_pend[IRQ_DMA] = 1'b1;
                end
            end
            FUNC_CONSUME_RX: n_rx_valid = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uart_ctrl  <= '0;
            r_uart_baud  <= '0;
            r_rx_byte    <= '0;
            r_rx_valid   <= 1'b0;
            r_timer_ctrl <= '0;
            r_timer_load <= '0;
            r_dma_src    <= '0;
            r_dma_dst    <= '0;
            r_dma_len    <= '0;
            r_dma_ctrl   <= '0;
            r_dma_status <= '0;
            r_dma_err    <= '0;
            r_irq_en     <= '0;
            r_irq_pend   <= '0;
            r_irq_act    <= '0;
            for (int k = 0; k < PERF_COUNT; k++) begin
                r_perf[k] <= '0;
            end
            r_perf_ctrl  <= '0;
        end else if (i_fire) begin
            r_uart_ctrl  <= n_uart_ctrl;
            r_uart_baud  <= n_uart_baud;
            r_rx_byte    <= n_rx_byte;
            r_rx_valid   <= n_rx_valid;
            r_timer_ctrl <= n_timer_ctrl;
            r_timer_load <= n_timer_load;
            r_dma_src    <= n_dma_src;
            r_dma_dst    <= n_dma_dst;
            r_dma_len    <= n_dma_len;
            r_dma_ctrl   <= n_dma_ctrl;
            r_dma_status <= n_dma_status;
            r_dma_err    <= n_dma_err;
            r_irq_en     <= n_irq_en;
            r_irq_pend   <= n_irq_pend;
            r_irq_act    <= n_irq_act;
            r_perf       <= n_perf;
            r_perf_ctrl  <= n_perf_ctrl;
        end
    end

`ifndef SYNTHESIS
    // The start bit must never be stored.
    a_start_self_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dma_ctrl[DMA_CTRL_START])
        else $error("DMA start bit was stored");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.func == FUNC_WRITE && i_req.reg_index == REG_DMA_CTRL
         && i_req.write_data[DMA_CTRL_START])
        |=> (r_dma_status == DMA_ST_BUSY && r_dma_err == '0))
        else $error("DMA start did not set busy");

    a_ack_retires_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.func == FUNC_READ && i_req.reg_index == REG_INTC_ACK
         && irq_ready != '0)
        |=> ($countones(r_irq_pend ^ $past(r_irq_pend)) == 1
             && r_irq_act != '0))
        else $error("Interrupt acknowledge did not retire exactly one line");
`endif

endmodule

>>> rtl/peripheral_register_file_intc.sv
`timescale 1ns / 1ps

// Peripheral register file with UART, timer, DMA, interrupt-controller and
// performance-counter registers behind a 5-bit register index (0..27, with
// a gap at 7..9; unmapped and higher indices read zero and ignore writes).
// Each input transfer is a bus read, a bus write or a hardware event (raise
// an interrupt line, finish or fail a DMA transfer, consume the UART receive
// byte), and each one produces exactly one output transfer carrying the read
// value, or zero for anything that is not a read. An item waits in the input
// register, is decoded there against the register state, and its result
// lands in the output register at the same edge that commits its side
// effects; the block sustains one item per cycle while the output is not
// stalled. Reading INTC_ACK returns the highest-priority pending and enabled
// line (TIMER over DMA over UART), retires it from pending into active, and
// returns all ones when nothing is ready. The input register keeps taking
// items while an unclaimed result waits in the output register as long as
// the input register itself is free.
module peripheral_register_file_intc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data
);
    import prfi_pkg::*;

    logic              r_in_valid;
    t_req              r_in_req;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] read_data;
    logic              advance;
    logic              in_fire;

    // The held item moves on when the output register is empty or its
    // contents are being taken in this cycle; that move is also when the
    // register file commits the item's side effects.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_fire = i_valid && !o_stall;

    prfi_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_req       (r_in_req),
        .o_read_data (read_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire) begin
            r_in_req.func       <= t_func'(i_func);
            r_in_req.reg_index  <= i_reg_index;
            r_in_req.write_data <= i_write_data;
        end
        if (advance) begin
            r_out_data <= read_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

`ifndef SYNTHESIS
    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("Input stalled with an empty input register");

    a_transfer_is_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_valid)
        else $error("Accepted item was lost from the input register");

    a_drain_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_in_valid) |=> !o_valid)
        else $error("Output valid without a new result");
`endif

endmodule
